>>> src/dsm_pkg.sv
`default_nettype none
package dsm_pkg;

	localparam int unsigned NUM_LANES = 3;

	// Lane order: queue, submit, execution.
	localparam int unsigned LANE_QUEUE  = 0;
	localparam int unsigned LANE_SUBMIT = 1;
	localparam int unsigned LANE_EXEC   = 2;

	localparam logic [1:0] OP_RECORD = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [3:0] STAT_COUNT       = 4'd0;
	localparam logic [3:0] STAT_EXEC_AVG    = 4'd1;
	localparam logic [3:0] STAT_EXEC_MAX    = 4'd2;
	localparam logic [3:0] STAT_EXEC_MIN    = 4'd3;
	localparam logic [3:0] STAT_QUEUE_AVG   = 4'd4;
	localparam logic [3:0] STAT_QUEUE_MAX   = 4'd5;
	localparam logic [3:0] STAT_QUEUE_MIN   = 4'd6;
	localparam logic [3:0] STAT_SUBMIT_AVG  = 4'd7;
	localparam logic [3:0] STAT_SUBMIT_MAX  = 4'd8;
	localparam logic [3:0] STAT_SUBMIT_MIN  = 4'd9;
	localparam logic [3:0] STAT_EXEC_LAST   = 4'd13;
	localparam logic [3:0] STAT_QUEUE_LAST  = 4'd14;
	localparam logic [3:0] STAT_SUBMIT_LAST = 4'd15;

	localparam logic [31:0] NS_PER_US = 32'd1000;
	localparam logic [31:0] ALL_ONES  = 32'hffff_ffff;

	typedef struct packed {
		logic start;
		logic clr;
	} dsm_lane_ctl_t;

	typedef struct packed {
		logic [31:0] avg;
		logic [31:0] max;
		logic [31:0] min;
		logic [31:0] last;
	} dsm_stats_t;

	function automatic logic [31:0] sat32(input logic [63:0] v);
		sat32 = (|v[63:32]) ? ALL_ONES : v[31:0];
	endfunction

endpackage
`default_nettype wire

>>> src/dsm_div.sv
`default_nettype none
module dsm_div
	import dsm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [63:0]      quotient
);

	// Restoring division, two quotient bits per cycle.
	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic [31:0] div_q;
	logic [31:0] rem_nx;
	logic [63:0] quo_nx;

	always_comb begin
		logic [32:0] t;
		logic        ge;
		rem_nx = rem_q;
		quo_nx = quo_q;
		for (int i = 0; i < 2; i++) begin
			t      = {rem_nx, quo_nx[63]};
			ge     = (t >= {1'b0, div_q});
			rem_nx = ge ? 32'(t - {1'b0, div_q}) : t[31:0];
			quo_nx = {quo_nx[62:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

>>> src/dsm_lane.sv
`default_nettype none
module dsm_lane
	import dsm_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire dsm_lane_ctl_t ctl,
	input  wire logic [63:0]   from_time,
	input  wire logic [63:0]   to_time,
	input  wire logic [31:0]   count,
	output logic               done,
	output dsm_stats_t         stats
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DUR  = 2'd1;
	localparam logic [1:0] ST_AVG  = 2'd2;
	localparam logic [1:0] ST_MEAN = 2'd3;

	logic [1:0]  state_q;
	logic [63:0] sum_q;
	logic [31:0] avg_q;
	logic [31:0] max_q;
	logic [31:0] min_q;
	logic [31:0] last_q;

	logic        div_start;
	logic [63:0] div_dividend;
	logic [31:0] div_divisor;
	logic        div_done;
	logic [63:0] div_quo;
	logic [31:0] dur;
	logic [64:0] sum_add;

	assign div_start    = ((state_q == ST_IDLE) && ctl.start) || (state_q == ST_AVG);
	assign div_dividend = (state_q == ST_IDLE) ? (to_time - from_time) : sum_q;
	assign div_divisor  = (state_q == ST_IDLE) ? NS_PER_US : count;

	dsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign dur     = sat32(div_quo);
	assign sum_add = {1'b0, sum_q} + {33'd0, dur};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q   <= '0;
			avg_q   <= '0;
			max_q   <= '0;
			min_q   <= ALL_ONES;
			last_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						state_q <= ST_DUR;
					end else if (ctl.clr) begin
						sum_q <= '0;
						avg_q <= '0;
						max_q <= '0;
						min_q <= ALL_ONES;
					end
				end
				ST_DUR: begin
					if (div_done) begin
						last_q  <= dur;
						sum_q   <= sum_add[64] ? '1 : sum_add[63:0];
						if (max_q < dur) max_q <= dur;
						if (min_q > dur) min_q <= dur;
						state_q <= ST_AVG;
					end
				end
				ST_AVG: begin
					state_q <= ST_MEAN;
				end
				ST_MEAN: begin
					if (div_done) begin
						avg_q   <= sat32(div_quo);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done       = (state_q == ST_MEAN) && div_done;
	assign stats.avg  = avg_q;
	assign stats.max  = max_q;
	assign stats.min  = min_q;
	assign stats.last = last_q;

endmodule
`default_nettype wire

>>> src/duration_statistics_monitor_unit.sv
`default_nettype none
// A read word is captured in the output register at the edge that accepts the read.
// Reads and clears do not hold the block; a record occupies it until both 64-bit divisions
// in each lane's shared divider, at two bits a cycle, are done.
// Reset (arst_n low) clears count, sums, averages, maxima and last values and sets the
// minima to all ones; the output word register starts empty.
module duration_statistics_monitor_unit
	import dsm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [63:0] queued_time,
	input  wire logic [63:0] submitted_time,
	input  wire logic [63:0] started_time,
	input  wire logic [63:0] ended_time,
	input  wire logic [3:0]  stat_index,
	input  wire logic        clear_after_read,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      stat_value
);

	// Three identical lanes work on the queue, submit and execution durations
	// in lockstep. The event count lives here, since every lane divides its sum
	// by the same count. The read multiplexer below is the merging stage.

	logic                  busy_q;
	logic [31:0]           count_q;
	logic                  out_valid_q;
	logic [31:0]           value_q;
	logic                  accept;
	logic                  out_free;
	logic                  do_clear;
	logic [31:0]           read_word;
	dsm_lane_ctl_t         lane_ctl;
	dsm_stats_t            lane_stats [NUM_LANES];
	logic [NUM_LANES-1:0]  lane_done;
	logic [63:0]           lane_from  [NUM_LANES];
	logic [63:0]           lane_to    [NUM_LANES];

	// The output register frees up in the same cycle its word is taken.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = busy_q || !out_free;
	assign accept   = in_valid && !in_stall;

	// A clear after a read happens at the same edge the word is captured; the
	// word is taken from the statistics before they are cleared.
	assign do_clear = accept && ((operation == OP_CLEAR) ||
		((operation == OP_READ) && clear_after_read));

	assign lane_ctl.start = accept && (operation == OP_RECORD);
	assign lane_ctl.clr   = do_clear;

	assign lane_from[LANE_QUEUE]  = queued_time;
	assign lane_to[LANE_QUEUE]    = submitted_time;
	assign lane_from[LANE_SUBMIT] = submitted_time;
	assign lane_to[LANE_SUBMIT]   = started_time;
	assign lane_from[LANE_EXEC]   = started_time;
	assign lane_to[LANE_EXEC]     = ended_time;

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		dsm_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (lane_ctl),
			.from_time (lane_from[g]),
			.to_time   (lane_to[g]),
			.count     (count_q),
			.done      (lane_done[g]),
			.stats     (lane_stats[g])
		);
	end

	// Merging stage: pick the requested word out of the lanes' statistics.
	// The reserved indices fall to the default arm and read as zero.
	always_comb begin
		case (stat_index)
			STAT_COUNT:       read_word = count_q;
			STAT_EXEC_AVG:    read_word = lane_stats[LANE_EXEC].avg;
			STAT_EXEC_MAX:    read_word = lane_stats[LANE_EXEC].max;
			STAT_EXEC_MIN:    read_word = lane_stats[LANE_EXEC].min;
			STAT_QUEUE_AVG:   read_word = lane_stats[LANE_QUEUE].avg;
			STAT_QUEUE_MAX:   read_word = lane_stats[LANE_QUEUE].max;
			STAT_QUEUE_MIN:   read_word = lane_stats[LANE_QUEUE].min;
			STAT_SUBMIT_AVG:  read_word = lane_stats[LANE_SUBMIT].avg;
			STAT_SUBMIT_MAX:  read_word = lane_stats[LANE_SUBMIT].max;
			STAT_SUBMIT_MIN:  read_word = lane_stats[LANE_SUBMIT].min;
			STAT_EXEC_LAST:   read_word = lane_stats[LANE_EXEC].last;
			STAT_QUEUE_LAST:  read_word = lane_stats[LANE_QUEUE].last;
			STAT_SUBMIT_LAST: read_word = lane_stats[LANE_SUBMIT].last;
			default:          read_word = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The lanes run in lockstep, so they all finish in the same cycle.
			if (lane_ctl.start) begin
				busy_q <= 1'b1;
			end else if (&lane_done) begin
				busy_q <= 1'b0;
			end

			// The count saturates; lanes see the new count before they divide.
			if (lane_ctl.start) begin
				if (count_q != ALL_ONES) count_q <= count_q + 32'd1;
			end else if (do_clear) begin
				count_q <= '0;
			end

			if (accept && (operation == OP_READ)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (operation == OP_READ)) begin
			value_q <= read_word;
		end
	end

	assign out_valid  = out_valid_q;
	assign stat_value = value_q;

endmodule
`default_nettype wire

>>> test/duration_statistics_monitor_unit_tb.sv
`timescale 1ns / 1ps

module duration_statistics_monitor_unit_tb;
	import dsm_pkg::*;

	// Operation code 3 has no meaning to the block; it is accepted and dropped.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// The watchdog gives up after this many cycles with no word accepted or delivered while
	// work is still outstanding. A record holds the block for both of its divisions and
	// the heaviest idling phase idles or stalls a side 79 percent of the time, so this is far above
	// anything a correct block produces.
	localparam int unsigned WATCHDOG_LIMIT = 3000;

	// One word as the sender presents it. Every field is carried for every
	// operation so that the fields the block should ignore still toggle.
	typedef struct {
		logic [1:0]  op;
		logic [63:0] queued;
		logic [63:0] submitted;
		logic [63:0] started;
		logic [63:0] ended;
		logic [3:0]  index;
		logic        clear_after;
	} monitor_word_t;

	logic        clk              = 1'b0;
	logic        arst_n           = 1'b0;
	logic        in_valid         = 1'b0;
	logic [1:0]  operation        = OP_RECORD;
	logic [63:0] queued_time      = '0;
	logic [63:0] submitted_time   = '0;
	logic [63:0] started_time     = '0;
	logic [63:0] ended_time       = '0;
	logic [3:0]  stat_index       = STAT_COUNT;
	logic        clear_after_read = 1'b0;
	logic        out_stall        = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [31:0] stat_value;

	duration_statistics_monitor_unit u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.operation        (operation),
		.queued_time      (queued_time),
		.submitted_time   (submitted_time),
		.started_time     (started_time),
		.ended_time       (ended_time),
		.stat_index       (stat_index),
		.clear_after_read (clear_after_read),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.stat_value       (stat_value)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Words waiting to be driven, the word on the bus, and the stat words that
	// reads have produced but the block has not yet delivered.
	monitor_word_t pending_words[$];
	monitor_word_t drive_word;
	logic [31:0]   expected_stat_values[$];
	logic          word_taken = 1'b0;

	// Idling of both sides, in percent of cycles; each phase sets its own mix.
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;

	int unsigned words_posted   = 0;
	int unsigned words_accepted = 0;
	int unsigned idle_cycles    = 0;
	int unsigned error_count    = 0;

	// Coverage tallies for the closing summary.
	int unsigned records_seen    = 0;
	int unsigned reads_seen      = 0;
	int unsigned read_clears     = 0;
	int unsigned clears_seen     = 0;
	int unsigned ignored_seen    = 0;
	int unsigned saturated_spans = 0;

	// Shadow copy of the statistics, one lane per duration (queue, submit,
	// execution), kept in step with every word the block accepts.
	logic [63:0] stat_sum  [NUM_LANES];
	logic [31:0] stat_avg  [NUM_LANES];
	logic [31:0] stat_max  [NUM_LANES];
	logic [31:0] stat_min  [NUM_LANES];
	logic [31:0] stat_last [NUM_LANES];
	logic [31:0] stat_count;

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= 200)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// A span in ns becomes microseconds. The subtraction wraps, so timestamps
	// out of order give a huge span that saturates to all ones.
	function automatic logic [31:0] to_micros(input logic [63:0] from_ns,
			input logic [63:0] to_ns);
		logic [63:0] quotient;
		quotient = (to_ns - from_ns) / {32'd0, NS_PER_US};
		return (quotient > {32'd0, ALL_ONES}) ? ALL_ONES : quotient[31:0];
	endfunction

	// Clearing keeps the last values; only reset zeroes those.
	task automatic clear_statistics();
		stat_count = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			stat_sum[i] = '0;
			stat_avg[i] = '0;
			stat_max[i] = '0;
			stat_min[i] = ALL_ONES;
		end
	endtask

	// Indices 10 to 12 are reserved and read as zero.
	function automatic logic [31:0] read_statistic(input logic [3:0] index);
		case (index)
		STAT_COUNT:       return stat_count;
		STAT_EXEC_AVG:    return stat_avg[LANE_EXEC];
		STAT_EXEC_MAX:    return stat_max[LANE_EXEC];
		STAT_EXEC_MIN:    return stat_min[LANE_EXEC];
		STAT_QUEUE_AVG:   return stat_avg[LANE_QUEUE];
		STAT_QUEUE_MAX:   return stat_max[LANE_QUEUE];
		STAT_QUEUE_MIN:   return stat_min[LANE_QUEUE];
		STAT_SUBMIT_AVG:  return stat_avg[LANE_SUBMIT];
		STAT_SUBMIT_MAX:  return stat_max[LANE_SUBMIT];
		STAT_SUBMIT_MIN:  return stat_min[LANE_SUBMIT];
		STAT_EXEC_LAST:   return stat_last[LANE_EXEC];
		STAT_QUEUE_LAST:  return stat_last[LANE_QUEUE];
		STAT_SUBMIT_LAST: return stat_last[LANE_SUBMIT];
		default:          return '0;
		endcase
	endfunction

	// Applies one accepted word to the shadow statistics. A read queues the word
	// the block must return; a clear after the read happens once it is taken.
	task automatic update_statistics(input monitor_word_t w);
		logic [31:0] span [NUM_LANES];
		logic [63:0] total;
		logic [63:0] mean;
		case (w.op)
		OP_RECORD: begin
			records_seen++;
			span[LANE_QUEUE]  = to_micros(w.queued, w.submitted);
			span[LANE_SUBMIT] = to_micros(w.submitted, w.started);
			span[LANE_EXEC]   = to_micros(w.started, w.ended);
			if (stat_count != ALL_ONES)
				stat_count = stat_count + 32'd1;
			for (int i = 0; i < NUM_LANES; i++) begin
				if (span[i] == ALL_ONES)
					saturated_spans++;
				// The sum sticks at all ones rather than wrapping.
				total = stat_sum[i] + {32'd0, span[i]};
				if (total < stat_sum[i])
					total = '1;
				stat_sum[i] = total;
				mean = total / {32'd0, stat_count};
				stat_avg[i] = (mean > {32'd0, ALL_ONES}) ? ALL_ONES : mean[31:0];
				stat_last[i] = span[i];
				if (stat_max[i] < span[i])
					stat_max[i] = span[i];
				if (stat_min[i] > span[i])
					stat_min[i] = span[i];
			end
		end
		OP_READ: begin
			reads_seen++;
			expected_stat_values.push_back(read_statistic(w.index));
			if (w.clear_after) begin
				read_clears++;
				clear_statistics();
			end
		end
		OP_CLEAR: begin
			clears_seen++;
			clear_statistics();
		end
		default: begin
			ignored_seen++;
		end
		endcase
	endtask

	task automatic post_word(input logic [1:0] op, input logic [63:0] q, input logic [63:0] s,
			input logic [63:0] st, input logic [63:0] e, input logic [3:0] index,
			input logic clear_after);
		monitor_word_t w;
		w.op          = op;
		w.queued      = q;
		w.submitted   = s;
		w.started     = st;
		w.ended       = e;
		w.index       = index;
		w.clear_after = clear_after;
		pending_words.push_back(w);
		words_posted++;
	endtask

	// The sender holds off here until every posted word is in and every read has
	// been answered. Waiting on the falling edge keeps clear of the monitor.
	task automatic wait_drained();
		while (words_accepted != words_posted || expected_stat_values.size() != 0)
			@(negedge clk);
	endtask

	// Span classes: under a microsecond, ordinary, long, right at the 32-bit
	// microsecond limit, huge, and negative (timestamps out of order).
	function automatic logic [63:0] random_span();
		case ($urandom_range(9))
		0:             return {32'd0, $urandom_range(999)};
		1, 2, 3, 4:    return {32'd0, $urandom_range(1000000)};
		5, 6:          return {24'd0, 8'($urandom_range(255)), $urandom()};
		7:             return 64'd4294967294000 + {32'd0, $urandom_range(2999)};
		8:             return {$urandom(), $urandom()};
		default:       return 64'd0 - {32'd0, $urandom_range(1, 5000)};
		endcase
	endfunction

	// Random traffic under one idling mix. Records are mostly well-formed chains
	// of timestamps from a random base; one in ten has four unrelated stamps.
	// Reads outnumber clears by far so that statistics build up between clears.
	// Ignored words do not count toward the phase length.
	task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned length);
		int unsigned posted;
		int unsigned pick;
		logic [63:0] stamp [4];
		logic [3:0]  index;
		logic        clear_after;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		posted = 0;
		while (posted < length) begin
			stamp[0] = {$urandom(), $urandom()};
			for (int k = 1; k < 4; k++)
				stamp[k] = stamp[k - 1] + random_span();
			index = 4'($urandom_range(15));
			clear_after = 1'($urandom_range(1));
			pick = $urandom_range(99);
			if (pick < 45) begin
				if ($urandom_range(9) == 0) begin
					for (int k = 0; k < 4; k++)
						stamp[k] = {$urandom(), $urandom()};
				end
				post_word(OP_RECORD, stamp[0], stamp[1], stamp[2], stamp[3], index,
					clear_after);
				posted++;
			end else if (pick < 92) begin
				clear_after = ($urandom_range(15) == 0);
				post_word(OP_READ, stamp[0], stamp[1], stamp[2], stamp[3], index,
					clear_after);
				posted++;
			end else if (pick < 97) begin
				post_word(OP_CLEAR, stamp[0], stamp[1], stamp[2], stamp[3], index,
					clear_after);
				posted++;
			end else begin
				post_word(OP_UNUSED, stamp[0], stamp[1], stamp[2], stamp[3], index,
					clear_after);
			end
		end
		wait_drained();
	endtask

	// Driver. Inputs change only on the falling edge. A word stays on the bus,
	// unchanged, until the monitor has seen it taken; only then may the sender
	// pick the next one or go idle. The idle decision never looks at in_stall.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || word_taken) begin
				word_taken = 1'b0;
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drive_word = pending_words.pop_front();
					in_valid         <= 1'b1;
					operation        <= drive_word.op;
					queued_time      <= drive_word.queued;
					submitted_time   <= drive_word.submitted;
					started_time     <= drive_word.started;
					ended_time       <= drive_word.ended;
					stat_index       <= drive_word.index;
					clear_after_read <= drive_word.clear_after;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Monitor and watchdog. On each rising edge the delivered stat word is checked
	// first against the oldest outstanding read, then an accepted input word is
	// applied to the shadow statistics. A read taken on this edge can only be
	// answered on a later one, so this order never pairs it with its own answer.
	always @(posedge clk) begin
		logic [31:0] want;
		logic        progress;
		if (arst_n) begin
			progress = 1'b0;
			if (out_valid && !out_stall) begin
				progress = 1'b1;
				if (expected_stat_values.size() == 0) begin
					report_mismatch($sformatf("stat word %h with no read outstanding",
						stat_value));
				end else begin
					want = expected_stat_values.pop_front();
					if (stat_value !== want)
						report_mismatch($sformatf("stat_value %h, should be %h",
							stat_value, want));
				end
			end
			if (in_valid && !in_stall) begin
				progress = 1'b1;
				word_taken = 1'b1;
				words_accepted++;
				update_statistics(drive_word);
			end
			// Only cycles with work outstanding count toward the watchdog, so the
			// sender's pauses between phases never trip it.
			if (progress || (words_accepted == words_posted &&
					expected_stat_values.size() == 0))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[%0t] watchdog: no word moved in %0d cycles", $time, idle_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		logic [3:0] index;

		// Shadow state after reset: statistics cleared and last values zero.
		clear_statistics();
		for (int i = 0; i < NUM_LANES; i++)
			stat_last[i] = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, with no idling on either side. Reset values come first:
		// the count reads zero and a minimum reads all ones.
		post_word(OP_READ, '0, '0, '0, '0, STAT_COUNT, 1'b0);
		post_word(OP_READ, '0, '0, '0, '0, STAT_EXEC_MIN, 1'b0);
		// Just under one microsecond, exactly one, and a plain 5000 us.
		post_word(OP_RECORD, 64'd0, 64'd999, 64'd1999, 64'd5001999, STAT_COUNT, 1'b0);
		// Timestamps out of order, a span that just fits 32 bits, and one that
		// is one microsecond too long.
		post_word(OP_RECORD, 64'd100, 64'd0, 64'd4294967295999,
			64'd4294967295999 + 64'd4294967296000, STAT_COUNT, 1'b0);
		// All-ones timestamps give zero everywhere and pull every minimum to zero.
		post_word(OP_RECORD, '1, '1, '1, '1, '1, 1'b1);
		// Every stat word, the reserved ones included.
		for (int i = 0; i < 16; i++) begin
			index = 4'(i);
			post_word(OP_READ, '0, '0, '0, '0, index, 1'b0);
		end
		// A read that clears afterwards, then a last value that survives the clear.
		post_word(OP_READ, '0, '0, '0, '0, STAT_SUBMIT_LAST, 1'b1);
		post_word(OP_READ, '0, '0, '0, '0, STAT_QUEUE_LAST, 1'b0);
		// A plain clear, then a word with the unused operation code, which must
		// leave no trace.
		post_word(OP_CLEAR, '1, '1, '1, '1, '1, 1'b1);
		post_word(OP_UNUSED, '1, '1, '1, '1, STAT_COUNT, 1'b1);
		post_word(OP_READ, '0, '0, '0, '0, STAT_COUNT, 1'b0);
		wait_drained();

		// Random part, one phase per idling mix; each phase ends with the sender
		// holding off until every read has been answered.
		run_phase(0, 0, 290);
		run_phase(79, 0, 290);
		run_phase(0, 79, 290);
		run_phase(34, 34, 290);

		// A record keeps the block busy for both of its divisions; give anything that
		// should not appear time to show up.
		repeat (100) @(posedge clk);
		@(negedge clk);
		if (expected_stat_values.size() != 0)
			report_mismatch($sformatf("%0d reads never answered",
				expected_stat_values.size()));

		$display("Covered %0d records (%0d saturated durations), %0d reads (%0d clearing),",
			records_seen, saturated_spans, reads_seen, read_clears);
		$display("%0d clears and %0d ignored words under four idling mixes; %0d mismatches.",
			clears_seen, ignored_seen, error_count);
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
